// ----- hw/rtl/jhs_pkg.sv -----
`default_nettype none

package jhs_pkg;

  // Marker bytes
  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] MarkerSoi    = 8'hD8;
  localparam logic [7:0] MarkerSof0   = 8'hC0;
  localparam logic [7:0] MarkerSof2   = 8'hC2;

  // Segment length limits: the length field counts itself, and a frame
  // header must include the width bytes.
  localparam logic [15:0] MinSegLen   = 16'd2;
  localparam logic [15:0] MinFrameLen = 16'd7;

  // Payload offsets of the dimension bytes inside a frame header
  localparam logic [15:0] OffHeightHi = 16'd3;
  localparam logic [15:0] OffHeightLo = 16'd4;
  localparam logic [15:0] OffWidthHi  = 16'd5;
  localparam logic [15:0] OffWidthLo  = 16'd6;

  typedef enum logic [1:0] {
    StatusFound   = 2'd0,
    StatusNotJpeg = 2'd1,
    StatusBroken  = 2'd2,
    StatusEnded   = 2'd3
  } scan_status_e;

  // One result beat from the parser
  typedef struct packed {
    logic         valid;
    logic [15:0]  width;
    logic [15:0]  height;
    scan_status_e status;
  } jhs_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/jhs_in_reg.sv -----
`default_nettype none

module jhs_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic       advance_i,
  output logic            s1_valid_o,
  output logic [7:0]      s1_byte_o,
  output logic            s1_last_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // Stall only while a held beat cannot move on
  assign in_stall_o = s1_valid_q & ~advance_i;
  assign s1_valid_d = in_stall_o ? s1_valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Payload capture on an accepted beat
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_byte_o  = s1_byte_q;
  assign s1_last_o  = s1_last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/jhs_parser.sv -----
`default_nettype none

module jhs_parser
  import jhs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output jhs_result_t     result_o
);

  typedef enum logic [7:0] {
    PhSoi0 = 8'b0000_0001,
    PhSoi1 = 8'b0000_0010,
    PhTag0 = 8'b0000_0100,
    PhTag1 = 8'b0000_1000,
    PhLen0 = 8'b0001_0000,
    PhLen1 = 8'b0010_0000,
    PhBody = 8'b0100_0000,
    PhDone = 8'b1000_0000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] seg_off_q, seg_off_d;
  logic [15:0] seg_len_q, seg_len_d;
  logic        is_frame_q, is_frame_d;
  logic [15:0] height_q, height_d;
  logic [15:0] width_q, width_d;

  logic [15:0] len_full;
  logic [15:0] off_next;
  jhs_result_t res;

  assign len_full = {seg_len_q[15:8], byte_i};
  assign off_next = seg_off_q + 16'd1;

  // Per-byte phase walk
  always_comb begin
    phase_d    = phase_q;
    seg_off_d  = seg_off_q;
    seg_len_d  = seg_len_q;
    is_frame_d = is_frame_q;
    height_d   = height_q;
    width_d    = width_q;
    res        = '{valid: 1'b0, width: 16'd0, height: 16'd0, status: StatusFound};

    case (phase_q)
      PhSoi0: begin
        if (byte_i != MarkerPrefix) begin
          res.valid  = 1'b1;
          res.status = StatusNotJpeg;
        end else begin
          phase_d = PhSoi1;
        end
      end
      PhSoi1: begin
        if (byte_i != MarkerSoi) begin
          res.valid  = 1'b1;
          res.status = StatusNotJpeg;
        end else begin
          phase_d = PhTag0;
        end
      end
      PhTag0: begin
        if (byte_i != MarkerPrefix) begin
          res.valid  = 1'b1;
          res.status = StatusBroken;
        end else begin
          phase_d = PhTag1;
        end
      end
      PhTag1: begin
        is_frame_d = (byte_i == MarkerSof0) || (byte_i == MarkerSof2);
        phase_d    = PhLen0;
      end
      PhLen0: begin
        seg_len_d = {byte_i, 8'd0};
        phase_d   = PhLen1;
      end
      PhLen1: begin
        seg_len_d = len_full;
        if ((len_full < MinSegLen) || (is_frame_q && (len_full < MinFrameLen))) begin
          res.valid  = 1'b1;
          res.status = StatusBroken;
        end else begin
          seg_off_d = MinSegLen;
          phase_d   = (len_full == MinSegLen) ? PhTag0 : PhBody;
        end
      end
      PhBody: begin
        if (is_frame_q && (seg_off_q == OffWidthLo)) begin
          // Width complete: frame size found
          res.valid  = 1'b1;
          res.width  = {width_q[15:8], byte_i};
          res.height = height_q;
          res.status = StatusFound;
        end else begin
          if (is_frame_q) begin
            if (seg_off_q == OffHeightHi)      height_d = {byte_i, 8'd0};
            else if (seg_off_q == OffHeightLo) height_d = {height_q[15:8], byte_i};
            else if (seg_off_q == OffWidthHi)  width_d  = {byte_i, 8'd0};
          end
          seg_off_d = off_next;
          if (off_next >= seg_len_q) phase_d = PhTag0;
        end
      end
      PhDone: begin
        // Rest of the image is skipped
      end
      default: begin
        phase_d = PhSoi0;
      end
    endcase

    if (res.valid) phase_d = PhDone;

    // Last byte: report early end if nothing given yet, then restart
    if (last_i) begin
      if ((phase_q != PhDone) && !res.valid) begin
        res.valid  = 1'b1;
        res.status = StatusEnded;
      end
      phase_d    = PhSoi0;
      seg_off_d  = 16'd0;
      seg_len_d  = 16'd0;
      is_frame_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhSoi0;
      seg_off_q  <= 16'd0;
      seg_len_q  <= 16'd0;
      is_frame_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      seg_off_q  <= seg_off_d;
      seg_len_q  <= seg_len_d;
      is_frame_q <= is_frame_d;
    end
  end

  // Captured dimension bytes
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      height_q <= height_d;
      width_q  <= width_d;
    end
  end

  assign result_o = res;

endmodule

`default_nettype wire

// ----- hw/rtl/jhs_out_reg.sv -----
`default_nettype none

module jhs_out_reg
  import jhs_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire jhs_result_t  result_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [15:0]       image_width_o,
  output logic [15:0]       image_height_o,
  output logic [1:0]        scan_status_o
);

  logic         out_valid_q, out_valid_d;
  logic [15:0]  width_q;
  logic [15:0]  height_q;
  scan_status_e status_q;
  logic         load;

  // Room for a new beat when empty or being taken this cycle
  assign free_o = ~out_valid_q | ~out_stall_i;
  assign load   = step_i & result_i.valid;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load)              out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      width_q  <= result_i.width;
      height_q <= result_i.height;
      status_q <= result_i.status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign image_width_o  = width_q;
  assign image_height_o = height_q;
  assign scan_status_o  = status_q;

endmodule

`default_nettype wire

// ----- hw/rtl/jpeg_header_size_scanner_core.sv -----
// Scans a JPEG byte stream, one byte per beat with a flag on the image's
// final byte, and returns at most one result per image: the frame width and
// height from the first SOF0/SOF2 header with status found, or status not
// JPEG, broken marker chain, or data ended first (width and height zero).
// The result comes on the beat that decides it; later bytes of the image are
// consumed without output until the last-byte flag, which restarts the scan.
// Throughput is one byte per cycle when not stalled: each accepted byte sits in
// an input register, then passes the phase and counter update into a result
// register, from which the result is offered to the output side. The
// only stall comes from a held result that the output side has not yet taken.
`default_nettype none

module jpeg_header_size_scanner_core
  import jhs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [15:0]     image_width_o,
  output logic [15:0]     image_height_o,
  output logic [1:0]      scan_status_o
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        out_free;
  logic        step;
  jhs_result_t result;

  // A held byte is parsed once the result register has room
  assign step = s1_valid & out_free;

  jhs_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .advance_i   (out_free),
    .s1_valid_o  (s1_valid),
    .s1_byte_o   (s1_byte),
    .s1_last_o   (s1_last)
  );

  jhs_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (s1_byte),
    .last_i   (s1_last),
    .result_o (result)
  );

  jhs_out_reg u_out_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .result_i       (result),
    .free_o         (out_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .scan_status_o  (scan_status_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/jpeg_header_size_scanner_core_tb.sv -----
`timescale 1ns / 1ps

module jpeg_header_size_scanner_core_tb;
  import jhs_pkg::*;

  localparam int IdleLimit     = 4000;
  localparam int HoldOffCycles = 300;
  localparam int SettleCycles  = 20;
  localparam int MaxShown      = 10;

  typedef enum logic [2:0] {
    ExpectSoiHi,
    ExpectSoiLo,
    ExpectTagHi,
    ExpectTagLo,
    ExpectLenHi,
    ExpectLenLo,
    SkipPayload,
    ImageDone
  } scan_phase_e;

  typedef struct {
    logic [15:0]  width;
    logic [15:0]  height;
    scan_status_e status;
  } size_report_t;

  // Tracks the marker walk of the current image and the size reports it owes
  class frame_size_scoreboard;
    scan_phase_e  scan_phase;
    logic [15:0]  seg_offset;
    logic [15:0]  seg_length;
    bit           in_frame_header;
    logic [15:0]  height_acc;
    logic [15:0]  width_acc;
    bit           reported;
    size_report_t expected_sizes[$];
    int           mismatches;
    int           reports_checked;
    int           status_count[4];

    function new();
      restart();
    endfunction

    function void restart();
      scan_phase      = ExpectSoiHi;
      seg_offset      = '0;
      seg_length      = '0;
      in_frame_header = 1'b0;
      height_acc      = '0;
      width_acc       = '0;
      reported        = 1'b0;
    endfunction

    function void post_report(logic [15:0] w, logic [15:0] h, scan_status_e st);
      size_report_t r;
      r.width  = w;
      r.height = h;
      r.status = st;
      expected_sizes.push_back(r);
      reported   = 1'b1;
      scan_phase = ImageDone;
    endfunction

    // One accepted input beat
    function void note_byte(logic [7:0] b, logic last);
      bit done;
      done = 1'b0;
      case (scan_phase)
        ExpectSoiHi: begin
          if (b != MarkerPrefix) post_report('0, '0, StatusNotJpeg);
          else scan_phase = ExpectSoiLo;
        end
        ExpectSoiLo: begin
          if (b != MarkerSoi) post_report('0, '0, StatusNotJpeg);
          else scan_phase = ExpectTagHi;
        end
        ExpectTagHi: begin
          if (b != MarkerPrefix) post_report('0, '0, StatusBroken);
          else scan_phase = ExpectTagLo;
        end
        ExpectTagLo: begin
          in_frame_header = (b == MarkerSof0) || (b == MarkerSof2);
          scan_phase = ExpectLenHi;
        end
        ExpectLenHi: begin
          seg_length = {b, 8'h00};
          scan_phase = ExpectLenLo;
        end
        ExpectLenLo: begin
          seg_length[7:0] = b;
          if (seg_length < MinSegLen || (in_frame_header && seg_length < MinFrameLen)) begin
            post_report('0, '0, StatusBroken);
          end else begin
            seg_offset = MinSegLen;
            scan_phase = (seg_length == MinSegLen) ? ExpectTagHi : SkipPayload;
          end
        end
        SkipPayload: begin
          if (in_frame_header) begin
            if (seg_offset == OffHeightHi) height_acc = {b, 8'h00};
            else if (seg_offset == OffHeightLo) height_acc[7:0] = b;
            else if (seg_offset == OffWidthHi) width_acc = {b, 8'h00};
            else if (seg_offset == OffWidthLo) begin
              width_acc[7:0] = b;
              post_report(width_acc, height_acc, StatusFound);
              done = 1'b1;
            end
          end
          if (!done) begin
            seg_offset = seg_offset + 16'd1;
            if (seg_offset >= seg_length) scan_phase = ExpectTagHi;
          end
        end
        default: ;
      endcase
      // final byte closes the image; a missing report becomes "ended first"
      if (last) begin
        if (!reported) post_report('0, '0, StatusEnded);
        restart();
      end
    endfunction

    // One accepted result beat, against the oldest owed report
    function void check_report(logic [15:0] w, logic [15:0] h, logic [1:0] st);
      size_report_t e;
      if (expected_sizes.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("[%0t] unexpected report: w=%0h h=%0h st=%0d", $realtime, w, h, st);
        return;
      end
      e = expected_sizes.pop_front();
      reports_checked++;
      status_count[e.status]++;
      if (w !== e.width || h !== e.height || st !== e.status) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("[%0t] report %0d: expected w=%0h h=%0h st=%0d, got w=%0h h=%0h st=%0d",
                   $realtime, reports_checked, e.width, e.height, e.status, w, h, st);
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic [1:0]  scan_status_o;

  frame_size_scoreboard sb;
  logic [7:0] image_bytes[$];
  int         idle_cycles   = 0;
  int         bytes_sent    = 0;
  int         images_sent   = 0;
  bit         sender_burst  = 1'b0;
  bit         hold_off_req  = 1'b0;

  jpeg_header_size_scanner_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .scan_status_o  (scan_status_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Beat monitor: both channels sampled at the edge that accepts them
  always @(posedge clk_i) begin : monitor_beats
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o === 1'b0) begin
        sb.note_byte(data_byte_i, last_byte_i);
        moved = 1'b1;
      end
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        sb.check_report(image_width_o, image_height_o, scan_status_o);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any accepted beat
  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("Watchdog: no beat accepted for %0d cycles", IdleLimit);
    $display("Verification failed");
    $finish;
  end

  // Result side back-pressure: mostly short stalls, some quiet stretches,
  // and a long hold-off on request
  initial begin : receiver
    int free_len;
    int stall_len;
    int r;
    forever begin
      r = $urandom_range(0, 99);
      free_len = (r < 10) ? $urandom_range(100, 200) : $urandom_range(1, 6);
      out_stall_i <= 1'b0;
      repeat (free_len) @(posedge clk_i);
      r = $urandom_range(0, 99);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_len = HoldOffCycles;
      end else if (r < 50) stall_len = 0;
      else if (r < 85) stall_len = $urandom_range(1, 3);
      else if (r < 97) stall_len = $urandom_range(4, 12);
      else stall_len = $urandom_range(20, 40);
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_burst || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sends image_bytes, flagging the final one
  task automatic send_image();
    int gap;
    for (int i = 0; i < image_bytes.size(); i++) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      data_byte_i <= image_bytes[i];
      last_byte_i <= (i == image_bytes.size() - 1);
      do @(posedge clk_i); while (in_stall_o !== 1'b0);
    end
    bytes_sent += image_bytes.size();
    images_sent++;
  endtask

  // Sender goes quiet until every owed report has come back
  task automatic wait_all_reported();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_sizes.size() != 0);
  endtask

  function automatic logic [15:0] pick_seg_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(2, 8));
    if (r < 95) return 16'($urandom_range(9, 24));
    return 16'($urandom_range(100, 700));
  endfunction

  function automatic logic [15:0] pick_frame_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'd7;
    if (r < 90) return 16'($urandom_range(8, 14));
    return 16'($urandom_range(100, 400));
  endfunction

  function automatic logic [15:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] pick_plain_tag();
    logic [7:0] t;
    t = 8'($urandom_range(0, 255));
    if (t == MarkerSof0 || t == MarkerSof2) t = 8'hE0;
    return t;
  endfunction

  function automatic logic [7:0] pick_sof_tag();
    return $urandom_range(0, 1) ? MarkerSof0 : MarkerSof2;
  endfunction

  // Tag, length and payload; dimension bytes land at their frame offsets
  function automatic void push_segment(logic [7:0] tag, logic [15:0] len,
                                       logic [15:0] h, logic [15:0] w);
    image_bytes.push_back(MarkerPrefix);
    image_bytes.push_back(tag);
    image_bytes.push_back(len[15:8]);
    image_bytes.push_back(len[7:0]);
    for (int k = 2; k < int'(len); k++) begin
      if (k == int'(OffHeightHi)) image_bytes.push_back(h[15:8]);
      else if (k == int'(OffHeightLo)) image_bytes.push_back(h[7:0]);
      else if (k == int'(OffWidthHi)) image_bytes.push_back(w[15:8]);
      else if (k == int'(OffWidthLo)) image_bytes.push_back(w[7:0]);
      else image_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void push_trailing(int max_n);
    repeat ($urandom_range(0, max_n)) image_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Mostly well-formed files with random content, plus broken and noise ones
  function automatic void build_random_image();
    int         kind;
    int         cut;
    logic [7:0] b;
    image_bytes.delete();
    kind = $urandom_range(0, 99);
    sender_burst = ($urandom_range(0, 99) < 20);
    if (kind >= 92) begin
      repeat ($urandom_range(1, 12)) image_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (kind >= 84) begin
      // bad start marker on either byte
      if ($urandom_range(0, 1)) begin
        image_bytes.push_back(8'($urandom_range(0, 254)));
      end else begin
        b = 8'($urandom_range(0, 255));
        if (b == MarkerSoi) b = 8'h00;
        image_bytes.push_back(MarkerPrefix);
        image_bytes.push_back(b);
      end
      push_trailing(6);
      return;
    end
    image_bytes.push_back(MarkerPrefix);
    image_bytes.push_back(MarkerSoi);
    repeat ($urandom_range(0, 3)) push_segment(pick_plain_tag(), pick_seg_len(),
                                               16'($urandom), 16'($urandom));
    if (kind < 60) begin
      push_segment(pick_sof_tag(), pick_frame_len(), pick_dim(), pick_dim());
      if ($urandom_range(0, 99) >= 40) push_trailing(8);
    end else if (kind < 66) begin
      // no frame header: stop at, or part way into, the last segment
      cut = $urandom_range(0, 3);
      repeat (cut) if (image_bytes.size() > 1) void'(image_bytes.pop_back());
    end else if (kind < 72) begin
      push_segment(pick_sof_tag(), pick_frame_len(), pick_dim(), pick_dim());
      cut = $urandom_range(1, image_bytes.size() - 1);
      repeat (cut) void'(image_bytes.pop_back());
    end else if (kind < 78) begin
      image_bytes.push_back(8'($urandom_range(0, 254)));
      push_trailing(6);
    end else begin
      // length too short, for a plain segment or a frame header
      image_bytes.push_back(MarkerPrefix);
      if ($urandom_range(0, 1)) begin
        image_bytes.push_back(pick_plain_tag());
        image_bytes.push_back(8'h00);
        image_bytes.push_back(8'($urandom_range(0, 1)));
      end else begin
        image_bytes.push_back(pick_sof_tag());
        image_bytes.push_back(8'h00);
        image_bytes.push_back(8'($urandom_range(0, 6)));
      end
      push_trailing(6);
    end
  endfunction

  task automatic run_random(int byte_budget);
    int n;
    int spent;
    n = 0;
    spent = 0;
    while (spent < byte_budget) begin
      if (n == 8) hold_off_req = 1'b1;
      build_random_image();
      send_image();
      spent += image_bytes.size();
      n++;
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: not JPEG on either start byte, early end, bad tag,
    // short frame header, and a found frame with extreme dimensions
    image_bytes = {8'h00};
    send_image();
    image_bytes = {8'hFF, 8'h00};
    send_image();
    image_bytes = {8'hFF, 8'hD8};
    send_image();
    image_bytes = {8'hFF, 8'hD8, 8'h7F};
    send_image();
    image_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hC2, 8'h00, 8'h06};
    send_image();
    image_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h07,
                   8'h08, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_image();
    wait_all_reported();

    run_random(800);
    wait_all_reported();

    // One long segment before the frame header
    image_bytes.delete();
    sender_burst = 1'b0;
    image_bytes.push_back(MarkerPrefix);
    image_bytes.push_back(MarkerSoi);
    push_segment(pick_plain_tag(), 16'd300, 16'($urandom), 16'($urandom));
    push_segment(MarkerSof2, 16'd7, pick_dim(), pick_dim());
    send_image();

    run_random(800);
    wait_all_reported();
    repeat (SettleCycles) @(posedge clk_i);

    if (sb.expected_sizes.size() != 0)
      $display("%0d expected reports never arrived", sb.expected_sizes.size());
    $display("Covered %0d images, %0d bytes, %0d reports checked, %0d mismatches",
             images_sent, bytes_sent, sb.reports_checked, sb.mismatches);
    $display("Reports: found %0d, not JPEG %0d, broken chain %0d, ended early %0d",
             sb.status_count[StatusFound], sb.status_count[StatusNotJpeg],
             sb.status_count[StatusBroken], sb.status_count[StatusEnded]);
    if (sb.mismatches == 0 && sb.expected_sizes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
